// ===== rtl/spwm_pkg.sv =====
// Shared types, constants and elaboration-time table functions for the sine PWM generator.
package spwm_pkg;

  localparam int CNT_W   = 10;
  localparam int CNT_MAX = 1023;
  localparam int AMP     = 32767;

  localparam logic [31:0] OFS_B  = 32'h5555_5555;
  localparam logic [31:0] OFS_C  = 32'hAAAA_AAAB;
  localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C234;

  // read sequencer slot codes
  localparam logic [1:0] SLOT_A = 2'd0;
  localparam logic [1:0] SLOT_B = 2'd1;
  localparam logic [1:0] SLOT_C = 2'd2;

  typedef struct packed {
    logic [CNT_W-1:0] a_high_count;
    logic [CNT_W-1:0] a_low_count;
    logic [CNT_W-1:0] b_high_count;
    logic [CNT_W-1:0] b_low_count;
    logic [CNT_W-1:0] c_high_count;
    logic [CNT_W-1:0] c_low_count;
  } spwm_res_t;

  // (a*b) >> 62 for Q2.62 operands, kept to 64 bits
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // unsigned 64-bit quotient by restoring long division; used at elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], n[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // trunc(32767*sin(pi/2 * k/q)), q = 2^(lbits-2); used at elaboration only
  function automatic int quarter_sine(input int k, input int lbits);
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  sum;
    logic [63:0]  dv;
    logic [127:0] prod;
    int           q;
    q = 1 << (lbits - 2);
    if (k == 0) return 0;
    if (k >= q) return AMP;
    x    = (PI_Q62 >> (lbits - 1)) * 64'(k);
    x2   = mul_q62(x, x);
    term = x;
    sum  = x;
    for (int n = 1; n <= 12; n++) begin
      dv   = 64'((2 * n) * (2 * n + 1));
      term = udiv64(mul_q62(term, x2), dv);
      if ((n & 1) != 0) sum = sum - term;
      else sum = sum + term;
    end
    prod = {64'd0, (sum >> 15)} * 128'(AMP);
    return int'(prod[78:47]);
  endfunction

  // floor(hp*(32767+s)/65534) with bit 0 cleared
  function automatic int high_count(input int s, input int hp);
    longint      num;
    logic [63:0] qv;
    int          h;
    num = longint'(hp) * longint'(AMP + s);
    qv  = udiv64(64'(num), 64'd65534);
    h   = int'(qv[31:0]);
    return h & ~1;
  endfunction

endpackage

// ===== rtl/spwm_in_if.sv =====
// Request channel carrying the update tick.
interface spwm_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

// ===== rtl/spwm_out_if.sv =====
// Result channel carrying the three phases' high and low counts.
interface spwm_out_if;
  logic                       valid;
  logic                       ready;
  logic [spwm_pkg::CNT_W-1:0] a_high_count;
  logic [spwm_pkg::CNT_W-1:0] a_low_count;
  logic [spwm_pkg::CNT_W-1:0] b_high_count;
  logic [spwm_pkg::CNT_W-1:0] b_low_count;
  logic [spwm_pkg::CNT_W-1:0] c_high_count;
  logic [spwm_pkg::CNT_W-1:0] c_low_count;

  modport source (output valid, output a_high_count, output a_low_count,
                  output b_high_count, output b_low_count,
                  output c_high_count, output c_low_count, input ready);
  modport sink   (input valid, input a_high_count, input a_low_count,
                  input b_high_count, input b_low_count,
                  input c_high_count, input c_low_count, output ready);
endinterface

// ===== rtl/spwm_rom.sv =====
// Quarter-wave sine ROM holding the PWM high count per phase address, registered read.
module spwm_rom #(
  parameter int LUT_ADDR_BITS = 10,
  parameter int HALF_PERIOD   = 1000
) (
  input  logic                                  clk,
  input  logic                                  rd_en,
  input  logic [LUT_ADDR_BITS-1:0]              rd_addr,
  output logic [$clog2(HALF_PERIOD+1)-1:0]      rd_high
);

  localparam int HW        = $clog2(HALF_PERIOD + 1);
  localparam int QTR       = 1 << (LUT_ADDR_BITS - 2);
  localparam int TAB_DEPTH = QTR + 1;
  localparam logic [LUT_ADDR_BITS-1:0] HALF_L = LUT_ADDR_BITS'(1 << (LUT_ADDR_BITS - 1));
  localparam logic [LUT_ADDR_BITS-2:0] QTR_L  = (LUT_ADDR_BITS-1)'(QTR);

  logic [HW-1:0] pos_tab [TAB_DEPTH];
  logic [HW-1:0] neg_tab [TAB_DEPTH];

  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    localparam int SV = spwm_pkg::quarter_sine(g, LUT_ADDR_BITS);
    localparam int HP = spwm_pkg::high_count(SV, HALF_PERIOD);
    localparam int HN = spwm_pkg::high_count(-SV, HALF_PERIOD);
    assign pos_tab[g] = HW'(HP);
    assign neg_tab[g] = HW'(HN);
  end

  logic                     neg;
  logic [LUT_ADDR_BITS-2:0] j;
  logic [LUT_ADDR_BITS-1:0] mirror;
  logic [LUT_ADDR_BITS-2:0] k;

  // fold the address onto the first quadrant; the top bit picks the negative half
  always_comb begin
    neg    = rd_addr[LUT_ADDR_BITS-1];
    j      = rd_addr[LUT_ADDR_BITS-2:0];
    mirror = HALF_L - {1'b0, j};
    k      = (j <= QTR_L) ? j : mirror[LUT_ADDR_BITS-2:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_high <= neg ? neg_tab[k] : pos_tab[k];
    end
  end

endmodule

// ===== rtl/three_phase_sine_pwm_generator.sv =====
// Top level of the three-phase sine PWM generator: phase accumulator, ROM sequencer, outputs.
//
// Usage:
//   in_ch  : request channel with a tick bit. A request with tick = 1 advances the
//            32-bit phase accumulator by cfg phase step and yields one result;
//            a request with tick = 0 is taken and dropped.
//   out_ch : one result per tick: high and low counts for phases A, B and C.
//   cfg_we / cfg_wdata : write the phase step; write only while the block is idle.
// Timing:
//   The three sine lookups share the single ROM read port, one per cycle while the
//   phase C read is not held, so a new tick request is taken only while idle or
//   alongside the phase C read of the one before. A result shows on out_ch.valid after
//   slot A read, B read, C read, ROM read register, result register, output register.
// Reset (rst_n low, synchronous): phase accumulator and phase step clear to zero,
//   all pending work is dropped.
// Stall: a result waits in the output register while out_ch.ready is low; one more
//   result may complete behind it, after which the phase C read holds and
//   in_ch.ready drops until the output drains.
module three_phase_sine_pwm_generator #(
  parameter int LUT_ADDR_BITS = 10,
  parameter int HALF_PERIOD   = 1000,
  parameter int LOW_OVERHEAD  = 10,
  parameter int HIGH_OVERHEAD = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  spwm_in_if.sink           in_ch,
  spwm_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);

  localparam int HW     = $clog2(HALF_PERIOD + 1);
  localparam int SW     = HW + 2;
  localparam int LO2    = LOW_OVERHEAD / 2;
  localparam int HI2    = HIGH_OVERHEAD / 2;
  localparam int FULL_I = (HALF_PERIOD - LO2 - HI2 < 0) ? 0 : (HALF_PERIOD - LO2 - HI2);

  localparam logic signed [SW-1:0] HP_S   = SW'(HALF_PERIOD);
  localparam logic signed [SW-1:0] LO2_S  = SW'(LO2);
  localparam logic signed [SW-1:0] HI2_S  = SW'(HI2);
  localparam logic signed [SW-1:0] FULL_S = SW'(FULL_I);

  localparam int CW = spwm_pkg::CNT_W;

  function automatic logic [CW-1:0] sat_cnt(input logic signed [SW-1:0] v);
    int t;
    t = int'(v);
    if (t < 0) return '0;
    if (t > spwm_pkg::CNT_MAX) return CW'(spwm_pkg::CNT_MAX);
    return t[CW-1:0];
  endfunction

  logic [31:0] phase_step_r;
  logic [31:0] phase_acc_r;
  logic [31:0] acc_nxt;
  logic [31:0] base_r;
  logic        busy_r;
  logic [1:0]  slot_r;

  logic        accept;
  logic        start;
  logic        res_free;
  logic        move;

  logic        iss_en;
  logic [31:0] iss_off;
  logic [31:0] iss_ph;

  logic        rd_vld_r;
  logic [1:0]  rd_slot_r;
  logic [HW-1:0] rd_high;

  logic signed [SW-1:0] high_s;
  logic signed [SW-1:0] lo_s;
  logic signed [SW-1:0] hi_s;
  logic [CW-1:0]        hi_cnt;
  logic [CW-1:0]        lo_cnt;

  logic [CW-1:0] a_hi_r;
  logic [CW-1:0] a_lo_r;
  logic [CW-1:0] b_hi_r;
  logic [CW-1:0] b_lo_r;

  spwm_pkg::spwm_res_t res_r;
  logic                res_vld_r;
  spwm_pkg::spwm_res_t out_r;
  logic                out_vld_r;

  assign move     = res_vld_r && (!out_vld_r || out_ch.ready);
  assign res_free = !res_vld_r || move;
  assign in_ch.ready = !busy_r || ((slot_r == spwm_pkg::SLOT_C) && res_free);
  assign accept   = in_ch.valid && in_ch.ready;
  assign start    = accept && in_ch.tick;
  assign acc_nxt  = phase_acc_r + phase_step_r;

  // issue one ROM read per cycle; hold the last one until the result slot frees
  always_comb begin
    unique case (slot_r)
      spwm_pkg::SLOT_A: begin
        iss_off = '0;
        iss_en  = busy_r;
      end
      spwm_pkg::SLOT_B: begin
        iss_off = spwm_pkg::OFS_B;
        iss_en  = busy_r;
      end
      spwm_pkg::SLOT_C: begin
        iss_off = spwm_pkg::OFS_C;
        iss_en  = busy_r && res_free;
      end
      default: begin
        iss_off = '0;
        iss_en  = 1'b0;
      end
    endcase
    iss_ph = base_r + iss_off;
  end

  spwm_rom #(
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .HALF_PERIOD   (HALF_PERIOD)
  ) u_rom (
    .clk     (clk),
    .rd_en   (iss_en),
    .rd_addr (iss_ph[31 -: LUT_ADDR_BITS]),
    .rd_high (rd_high)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= '0;
    end else if (cfg_we) begin
      phase_step_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r <= '0;
      busy_r      <= 1'b0;
      slot_r      <= spwm_pkg::SLOT_A;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= iss_en;
      if (start) begin
        phase_acc_r <= acc_nxt;
        busy_r      <= 1'b1;
        slot_r      <= spwm_pkg::SLOT_A;
      end else if (iss_en) begin
        unique case (slot_r)
          spwm_pkg::SLOT_A: slot_r <= spwm_pkg::SLOT_B;
          spwm_pkg::SLOT_B: slot_r <= spwm_pkg::SLOT_C;
          default:          busy_r <= 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      base_r <= acc_nxt;
    end
    rd_slot_r <= slot_r;
  end

  // turn the high count into the overhead-adjusted pair
  always_comb begin
    high_s = SW'($signed({1'b0, rd_high}));
    lo_s   = HP_S - high_s - LO2_S;
    hi_s   = high_s - HI2_S;
    if (lo_s <= 0) begin
      lo_s = '0;
      hi_s = FULL_S;
    end
    if (hi_s <= 0) begin
      hi_s = '0;
      lo_s = FULL_S;
    end
    hi_cnt = sat_cnt(hi_s);
    lo_cnt = sat_cnt(lo_s);
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      unique case (rd_slot_r)
        spwm_pkg::SLOT_A: begin
          a_hi_r <= hi_cnt;
          a_lo_r <= lo_cnt;
        end
        spwm_pkg::SLOT_B: begin
          b_hi_r <= hi_cnt;
          b_lo_r <= lo_cnt;
        end
        default: begin
          res_r.a_high_count <= a_hi_r;
          res_r.a_low_count  <= a_lo_r;
          res_r.b_high_count <= b_hi_r;
          res_r.b_low_count  <= b_lo_r;
          res_r.c_high_count <= hi_cnt;
          res_r.c_low_count  <= lo_cnt;
        end
      endcase
    end
    if (move) begin
      out_r <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (rd_vld_r && (rd_slot_r == spwm_pkg::SLOT_C)) begin
        res_vld_r <= 1'b1;
      end else if (move) begin
        res_vld_r <= 1'b0;
      end
      if (move) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.a_high_count = out_r.a_high_count;
  assign out_ch.a_low_count  = out_r.a_low_count;
  assign out_ch.b_high_count = out_r.b_high_count;
  assign out_ch.b_low_count  = out_r.b_low_count;
  assign out_ch.c_high_count = out_r.c_high_count;
  assign out_ch.c_low_count  = out_r.c_low_count;

endmodule

// ===== dv/tb_three_phase_sine_pwm_generator.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the three-phase sine PWM generator with its own phase/ROM predictor.
module tb_three_phase_sine_pwm_generator;

  localparam int ROM_AW    = 10;
  localparam int ROM_DEPTH = 1 << ROM_AW;
  localparam int QTR      = ROM_DEPTH / 4;
  localparam int HALF     = 1000;
  localparam int LOW_OVH  = 10;
  localparam int HIGH_OVH = 6;
  localparam int FULL_CNT = HALF - LOW_OVH / 2 - HIGH_OVH / 2;
  localparam int SINE_AMP = 32767;
  localparam logic [31:0] PH_B    = 32'h5555_5555;
  localparam logic [31:0] PH_C    = 32'hAAAA_AAAB;
  localparam logic [63:0] PI_FX62 = 64'hC90F_DAA2_2168_C234;
  localparam int SEGS      = 8;
  localparam int SEG_TICKS = 208;
  localparam int SETTLE    = 12;

  // idle patterns: sender 22 / receiver 54, then swapped, then none
  localparam int IDLE_RX_HEAVY = 0;
  localparam int IDLE_TX_HEAVY = 1;
  localparam int IDLE_NONE     = 2;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  spwm_in_if  in_ch ();
  spwm_out_if out_ch ();

  three_phase_sine_pwm_generator #(
    .LUT_ADDR_BITS(ROM_AW),
    .HALF_PERIOD  (HALF),
    .LOW_OVERHEAD (LOW_OVH),
    .HIGH_OVERHEAD(HIGH_OVH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  int                  sine_tab [ROM_DEPTH];
  logic                tick_q [$];
  spwm_pkg::spwm_res_t counts_q [$];
  logic [31:0]         phase_acc_m;
  logic [31:0]         phase_step_m;
  int                  idle_mode;
  int                  seg_no;
  logic                rx_block;
  int                  errors;
  int                  n_requests;
  int                  n_ticks;
  int                  n_results;
  int                  n_settings;

  always #4 clk = ~clk;

  // (a*b) >> 62 on Q2.62 values
  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // trunc(32767*sin(pi/2 * k/QTR)) by Taylor series
  function automatic int quarter_wave(input int k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] acc;
    if (k == 0) return 0;
    if (k >= QTR) return SINE_AMP;
    x   = (PI_FX62 >> (ROM_AW - 1)) * 64'(k);
    x2  = q62_mul(x, x);
    t   = x;
    acc = x;
    for (int n = 1; n <= 12; n++) begin
      t = q62_mul(t, x2) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - t;
      else acc = acc + t;
    end
    return int'(((acc >> 15) * 64'(SINE_AMP)) >> 47);
  endfunction

  function automatic void pwm_pair(input logic [31:0] ph,
                                   output logic [spwm_pkg::CNT_W-1:0] hi_c,
                                   output logic [spwm_pkg::CNT_W-1:0] lo_c);
    int     s;
    int     high;
    int     h;
    int     l;
    longint num;
    s    = sine_tab[ph[31 -: ROM_AW]];
    num  = longint'(HALF) * longint'(SINE_AMP + s);
    high = int'(num / (2 * SINE_AMP)) & ~1;
    h    = high - HIGH_OVH / 2;
    l    = (HALF - high) - LOW_OVH / 2;
    // low side collapses first, then the high side
    if (l <= 0) begin
      l = 0;
      h = (FULL_CNT < 0) ? 0 : FULL_CNT;
    end
    if (h <= 0) begin
      h = 0;
      l = (FULL_CNT < 0) ? 0 : FULL_CNT;
    end
    hi_c = (h > spwm_pkg::CNT_MAX) ? spwm_pkg::CNT_MAX[spwm_pkg::CNT_W-1:0]
                                   : h[spwm_pkg::CNT_W-1:0];
    lo_c = (l > spwm_pkg::CNT_MAX) ? spwm_pkg::CNT_MAX[spwm_pkg::CNT_W-1:0]
                                   : l[spwm_pkg::CNT_W-1:0];
  endfunction

  function automatic spwm_pkg::spwm_res_t three_phase_counts(input logic [31:0] ph);
    spwm_pkg::spwm_res_t r;
    pwm_pair(ph,        r.a_high_count, r.a_low_count);
    pwm_pair(ph + PH_B, r.b_high_count, r.b_low_count);
    pwm_pair(ph + PH_C, r.c_high_count, r.c_low_count);
    return r;
  endfunction

  // request side
  always @(posedge clk) begin : tick_driver
    int roll;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.tick  <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        n_requests++;
        if (in_ch.tick) begin
          phase_acc_m = phase_acc_m + phase_step_m;
          counts_q.push_back(three_phase_counts(phase_acc_m));
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        roll = $urandom_range(0, 99);
        if (tick_q.size() != 0 &&
            !(idle_mode == IDLE_RX_HEAVY && roll < 22) &&
            !(idle_mode == IDLE_TX_HEAVY && roll < 54)) begin
          in_ch.valid <= 1'b1;
          in_ch.tick  <= tick_q.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin : count_monitor
    int                  roll;
    spwm_pkg::spwm_res_t got;
    spwm_pkg::spwm_res_t want;
    string               fname [6];
    fname = '{"a_high_count", "a_low_count", "b_high_count",
              "b_low_count", "c_high_count", "c_low_count"};
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.a_high_count, out_ch.a_low_count, out_ch.b_high_count,
                out_ch.b_low_count, out_ch.c_high_count, out_ch.c_low_count};
        if (counts_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected nothing, got %h", $time, got);
        end else begin
          want = counts_q.pop_front();
          n_results++;
          for (int f = 0; f < 6; f++) begin
            if (got[(5 - f) * spwm_pkg::CNT_W +: spwm_pkg::CNT_W] !==
                want[(5 - f) * spwm_pkg::CNT_W +: spwm_pkg::CNT_W]) begin
              errors++;
              $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname[f],
                       want[(5 - f) * spwm_pkg::CNT_W +: spwm_pkg::CNT_W],
                       got[(5 - f) * spwm_pkg::CNT_W +: spwm_pkg::CNT_W]);
            end
          end
        end
      end
      roll = $urandom_range(0, 99);
      out_ch.ready <= !rx_block &&
                      !(idle_mode == IDLE_RX_HEAVY && roll < 54) &&
                      !(idle_mode == IDLE_TX_HEAVY && roll < 22);
    end
  end

  // hold the result side off long enough to back the block up
  initial begin
    rx_block = 1'b0;
    wait (seg_no == 1);
    @(posedge clk);
    rx_block <= 1'b1;
    repeat (150) @(posedge clk);
    rx_block <= 1'b0;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // wait until every request is taken and every result is back
  task automatic drain();
    @(negedge clk);
    while (tick_q.size() != 0 || in_ch.valid || counts_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_step(input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    phase_step_m = v;
    n_settings++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_ticks(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        tick_q.push_back(1'b0);
      end else begin
        tick_q.push_back(1'b1);
        sent++;
      end
    end
    n_ticks += count;
  endtask

  initial begin
    logic [31:0] seg_step [SEGS];
    int          j;
    int          k;
    int          v;
    clk          = 1'b0;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.tick   = 1'b0;
    out_ch.ready = 1'b0;
    idle_mode    = IDLE_RX_HEAVY;
    seg_no       = -1;
    errors       = 0;
    n_requests   = 0;
    n_ticks      = 0;
    n_results    = 0;
    n_settings   = 0;
    phase_acc_m  = '0;
    phase_step_m = '0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      j = (i < ROM_DEPTH / 2) ? i : i - ROM_DEPTH / 2;
      k = (j <= QTR) ? j : ROM_DEPTH / 2 - j;
      v = quarter_wave(k);
      sine_tab[i] = (i < ROM_DEPTH / 2) ? v : -v;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // step left at its reset value: phase stays at zero, dropped tick in between
    tick_q = '{1'b1, 1'b0, 1'b1};
    n_ticks += 2;
    drain();
    // quarter turns: peak, zero crossing, trough, wrap back to zero
    write_step(32'h4000_0000);
    tick_q = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    n_ticks += 4;
    drain();
    // largest step walks backward through the top of the table
    write_step(32'hFFFF_FFFF);
    tick_q = '{1'b1, 1'b1, 1'b1};
    n_ticks += 3;
    drain();
    // one table entry per tick across the wrap
    write_step(32'h0040_0000);
    tick_q = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
    n_ticks += 6;
    drain();

    seg_step = '{$urandom, 32'h0040_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                 32'($urandom_range(0, 32'h00FF_FFFF)), 32'h0000_0001, $urandom,
                 32'h0000_0000};
    for (int s = 0; s < SEGS; s++) begin
      idle_mode = (s < 3) ? IDLE_RX_HEAVY : (s < 6) ? IDLE_TX_HEAVY : IDLE_NONE;
      write_step(seg_step[s]);
      seg_no = s;
      push_ticks(SEG_TICKS / 2);
      // sender pauses here until the block is empty
      drain();
      push_ticks(SEG_TICKS - SEG_TICKS / 2);
      drain();
    end

    $display("Run: %0d requests taken (%0d ticks), %0d results compared,", n_requests,
             n_ticks, n_results);
    $display("     %0d phase-step settings including 0, 1, half turn and all ones", n_settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
